@@ design/swnr_pkg.sv @@
package swnr_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 7;
	localparam int CFG_W    = 9;
	localparam int HIST_W   = 9;

	// histogram bins saturate here
	localparam logic [HIST_W-1:0] HIST_MAX = '1;

	// configuration register indexes
	localparam logic [0:0] REG_WINDOW_LEN = 1'b0;
	localparam logic [0:0] REG_RANK       = 1'b1;

	// microprogram step address
	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE    = 3'd0;
	localparam step_t STEP_RD_IN   = 3'd1;
	localparam step_t STEP_WR_IN   = 3'd2;
	localparam step_t STEP_RD_OLD  = 3'd3;
	localparam step_t STEP_WR_OLD  = 3'd4;
	localparam step_t STEP_SCAN_RD = 3'd5;
	localparam step_t STEP_SCAN    = 3'd6;
	localparam step_t STEP_EMIT    = 3'd7;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NEVER     = 3'd0,
		COND_NO_ITEM   = 3'd1,
		COND_SHORT     = 3'd2,
		COND_SCAN_MORE = 3'd3,
		COND_OUT_BUSY  = 3'd4
	} cond_t;

	// one control word
	typedef struct packed {
		logic  accept;    // take an item from the input side
		logic  rd_in;     // read entering bin and leaving sample
		logic  wr_in;     // write incremented entering bin
		logic  rd_old;    // read bin of leaving sample
		logic  wr_old;    // write decremented leaving bin
		logic  commit;    // store sample, advance pointer and fill count
		logic  scan_rd;   // first bin read of the rank scan
		logic  scan_acc;  // accumulate one bin, read the next
		logic  emit;      // load output register
		cond_t cond;
		step_t target;
	} ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic short_win;
		logic scan_more;
		logic out_busy;
	} stat_t;

	// control store
	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		w = '0;
		w.cond = COND_NEVER;
		w.target = STEP_IDLE;
		unique case (step)
			STEP_IDLE: begin
				w.accept = 1'b1;
				w.cond = COND_NO_ITEM;
				w.target = STEP_IDLE;
			end
			STEP_RD_IN: begin
				w.rd_in = 1'b1;
			end
			STEP_WR_IN: begin
				w.wr_in = 1'b1;
			end
			STEP_RD_OLD: begin
				w.rd_old = 1'b1;
			end
			STEP_WR_OLD: begin
				w.wr_old = 1'b1;
				w.commit = 1'b1;
				w.cond = COND_SHORT;
				w.target = STEP_IDLE;
			end
			STEP_SCAN_RD: begin
				w.scan_rd = 1'b1;
			end
			STEP_SCAN: begin
				w.scan_acc = 1'b1;
				w.cond = COND_SCAN_MORE;
				w.target = STEP_SCAN;
			end
			STEP_EMIT: begin
				w.emit = 1'b1;
				w.cond = COND_OUT_BUSY;
				w.target = STEP_EMIT;
			end
		endcase
		return w;
	endfunction

endpackage

@@ design/swnr_seq.sv @@
module swnr_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  swnr_pkg::stat_t     stat,
	output swnr_pkg::ctl_t      ctl
);

	swnr_pkg::step_t step_q;
	logic            jump;

	// control word of the current step
	assign ctl = swnr_pkg::ucode(step_q);

	// jump condition select
	always_comb begin
		unique case (ctl.cond)
			swnr_pkg::COND_NEVER:     jump = 1'b0;
			swnr_pkg::COND_NO_ITEM:   jump = ~in_valid;
			swnr_pkg::COND_SHORT:     jump = stat.short_win;
			swnr_pkg::COND_SCAN_MORE: jump = stat.scan_more;
			swnr_pkg::COND_OUT_BUSY:  jump = stat.out_busy;
			default:                  jump = 1'b0;
		endcase
	end

	// step counter, last step wraps to idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= swnr_pkg::STEP_IDLE;
		end else if (jump) begin
			step_q <= ctl.target;
		end else begin
			step_q <= step_q + 3'd1;
		end
	end

endmodule

@@ design/swnr_hist.sv @@
module swnr_hist #(
	parameter int DEPTH = 50,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [swnr_pkg::HIST_W-1:0]   rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [swnr_pkg::HIST_W-1:0]   wr_data
);

	logic [swnr_pkg::HIST_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]            valid_q;
	logic [swnr_pkg::HIST_W-1:0] rd_data_q;

	// per-bin valid bits, an invalid bin reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// bin storage with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/swnr_dp.sv @@
module swnr_dp #(
	parameter int WINDOW_MAX = 256,
	parameter int VALUE_SPAN = 50
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  swnr_pkg::ctl_t                        ctl,
	input  logic                                  in_valid,
	input  logic signed [swnr_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  new_sequence,
	input  logic [swnr_pkg::CFG_W-1:0]            window_len,
	input  logic [swnr_pkg::CFG_W-1:0]            rank,
	input  logic                                  out_stall,
	output swnr_pkg::stat_t                       stat,
	output logic                                  out_valid,
	output logic signed [swnr_pkg::SAMPLE_W-1:0]  beauty
);

	localparam int PW = $clog2(WINDOW_MAX);
	localparam int FW = $clog2(WINDOW_MAX + 1);
	localparam int LW = (FW > swnr_pkg::CFG_W) ? FW : swnr_pkg::CFG_W;
	localparam int BW = (VALUE_SPAN > 1) ? $clog2(VALUE_SPAN) : 1;
	localparam int JW = $clog2(VALUE_SPAN + 1);
	localparam int CW = $clog2(VALUE_SPAN * ((1 << swnr_pkg::HIST_W) - 1) + 1);
	localparam int SW = swnr_pkg::SAMPLE_W + 2;
	localparam int RW = JW + swnr_pkg::SAMPLE_W + 2;
	localparam logic signed [SW-1:0] SPAN_S = SW'(VALUE_SPAN);

	logic [swnr_pkg::SAMPLE_W-1:0] win_mem [WINDOW_MAX];

	logic [swnr_pkg::SAMPLE_W-1:0] sample_q;
	logic [swnr_pkg::SAMPLE_W-1:0] old_q;
	logic [FW-1:0]                 fill_q;
	logic [PW-1:0]                 wp_q;
	logic [JW-1:0]                 j_q;
	logic [CW-1:0]                 cum_q;
	logic [swnr_pkg::SAMPLE_W-1:0] res_q;
	logic [swnr_pkg::SAMPLE_W-1:0] beauty_q;
	logic                          out_valid_q;

	logic [LW-1:0]                 len_ext;
	logic [FW-1:0]                 len_c;
	logic [swnr_pkg::CFG_W-1:0]    want;
	logic [FW:0]                   wrap_sum;
	logic [PW-1:0]                 old_idx;
	logic [FW-1:0]                 fill_inc;
	logic                          accept;
	logic                          in_neg;
	logic                          old_live;
	logic [BW-1:0]                 in_bin;
	logic [BW-1:0]                 old_bin;
	logic                          hist_rd_en;
	logic [BW-1:0]                 hist_rd_addr;
	logic [swnr_pkg::HIST_W-1:0]   hist_rd_data;
	logic                          hist_wr_en;
	logic [BW-1:0]                 hist_wr_addr;
	logic [swnr_pkg::HIST_W-1:0]   hist_wr_data;
	logic [CW-1:0]                 cum_sum;
	logic                          hit;
	logic                          more;
	logic [RW-1:0]                 res_wide;
	logic                          out_load;

	// bin of a negative sample, values below the span share the lowest bin
	function automatic logic [BW-1:0] bin_of(input logic [swnr_pkg::SAMPLE_W-1:0] v);
		logic signed [SW-1:0] sx;
		logic signed [SW-1:0] sum;
		sx = SW'($signed(v));
		sum = sx + SPAN_S;
		if (sx < -SPAN_S) begin
			return '0;
		end
		return BW'(sum);
	endfunction

	// clamp window length and rank to their legal ranges
	assign len_ext = LW'(window_len);
	always_comb begin
		if (window_len == '0) begin
			len_c = FW'(1);
		end else if (len_ext > LW'(WINDOW_MAX)) begin
			len_c = FW'(WINDOW_MAX);
		end else begin
			len_c = FW'(len_ext);
		end
	end
	assign want = (rank == '0) ? swnr_pkg::CFG_W'(1) : rank;

	// slot of the sample leaving the window
	assign wrap_sum = (FW+1)'(wp_q) + (FW+1)'(WINDOW_MAX) - (FW+1)'(len_c);
	always_comb begin
		if (FW'(wp_q) >= len_c) begin
			old_idx = PW'(FW'(wp_q) - len_c);
		end else begin
			old_idx = PW'(wrap_sum);
		end
	end

	assign fill_inc = (fill_q == FW'(WINDOW_MAX)) ? fill_q : fill_q + FW'(1);
	assign accept   = ctl.accept & in_valid;
	assign in_neg   = sample_q[swnr_pkg::SAMPLE_W-1];
	assign old_live = (fill_q >= len_c) & old_q[swnr_pkg::SAMPLE_W-1];
	assign in_bin   = bin_of(sample_q);
	assign old_bin  = bin_of(old_q);

	// scan accumulate and compare against the rank
	assign cum_sum  = cum_q + CW'(hist_rd_data);
	assign hit      = cum_sum >= CW'(want);
	assign more     = ~hit & (j_q != JW'(VALUE_SPAN));
	assign res_wide = RW'(j_q) - RW'(1) - RW'(VALUE_SPAN);

	// histogram port selection
	always_comb begin
		priority if (ctl.rd_in) begin
			hist_rd_addr = in_bin;
		end else if (ctl.rd_old) begin
			hist_rd_addr = old_bin;
		end else begin
			hist_rd_addr = BW'(j_q);
		end
	end
	assign hist_rd_en   = ctl.rd_in | ctl.rd_old | ctl.scan_rd | (ctl.scan_acc & more);
	assign hist_wr_en   = (ctl.wr_in & in_neg) | (ctl.wr_old & old_live);
	assign hist_wr_addr = ctl.wr_in ? in_bin : old_bin;
	always_comb begin
		if (ctl.wr_in) begin
			hist_wr_data = (hist_rd_data == swnr_pkg::HIST_MAX) ? hist_rd_data
			                                                     : hist_rd_data + 1'b1;
		end else begin
			hist_wr_data = (hist_rd_data == '0) ? hist_rd_data : hist_rd_data - 1'b1;
		end
	end

	swnr_hist #(
		.DEPTH (VALUE_SPAN),
		.AW    (BW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (accept & new_sequence),
		.rd_en   (hist_rd_en),
		.rd_addr (hist_rd_addr),
		.rd_data (hist_rd_data),
		.wr_en   (hist_wr_en),
		.wr_addr (hist_wr_addr),
		.wr_data (hist_wr_data)
	);

	// delay line
	always_ff @(posedge clk) begin
		if (ctl.rd_in) begin
			old_q <= win_mem[old_idx];
		end
		if (ctl.commit) begin
			win_mem[wp_q] <= sample_q;
		end
	end

	// item payload, scan accumulator and result
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (ctl.commit) begin
			cum_q <= '0;
		end else if (ctl.scan_acc & more) begin
			cum_q <= cum_sum;
		end
		if (ctl.scan_acc & ~more) begin
			res_q <= hit ? res_wide[swnr_pkg::SAMPLE_W-1:0] : '0;
		end
		if (out_load) begin
			beauty_q <= res_q;
		end
	end

	// sequence position and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wp_q <= '0;
			j_q <= '0;
		end else begin
			if (accept & new_sequence) begin
				fill_q <= '0;
				wp_q <= '0;
			end else if (ctl.commit) begin
				fill_q <= fill_inc;
				wp_q <= (wp_q == PW'(WINDOW_MAX - 1)) ? '0 : wp_q + PW'(1);
			end
			if (ctl.commit) begin
				j_q <= '0;
			end else if (ctl.scan_rd | (ctl.scan_acc & more)) begin
				j_q <= j_q + JW'(1);
			end
		end
	end

	// output register
	assign out_load = ctl.emit & ~(out_valid_q & out_stall);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.short_win = fill_inc < len_c;
	assign stat.scan_more = more;
	assign stat.out_busy  = out_valid_q & out_stall;
	assign out_valid      = out_valid_q;
	assign beauty         = $signed(beauty_q);

endmodule

@@ design/sliding_window_negative_rank_unit.sv @@
// an item accepted while the window is still filling gives no result; once the window is full
// the result follows the entering and leaving bin updates and a scan of k bins (1..VALUE_SPAN)
// a new item is taken only after the previous one is done, in the idle step, and the output
// load waits while a stalled result is held; the one-bin-per-cycle histogram scan sets the pace
// reset: arst_n clears sequencer, histogram valid bits, fill count and pointer at once;
// window_len and rank return to 1; the delay line is not cleared
module sliding_window_negative_rank_unit #(
	parameter int WINDOW_MAX = 256,
	parameter int VALUE_SPAN = 50
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [swnr_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  new_sequence,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [swnr_pkg::SAMPLE_W-1:0]  beauty,
	input  logic                                  write_enable,
	input  logic [0:0]                            write_index,
	input  logic [swnr_pkg::CFG_W-1:0]            write_data
);

	logic [swnr_pkg::CFG_W-1:0] window_len_q;
	logic [swnr_pkg::CFG_W-1:0] rank_q;
	swnr_pkg::ctl_t             ctl;
	swnr_pkg::stat_t            stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= swnr_pkg::CFG_W'(1);
			rank_q <= swnr_pkg::CFG_W'(1);
		end else if (write_enable) begin
			unique case (write_index)
				swnr_pkg::REG_WINDOW_LEN: window_len_q <= write_data;
				swnr_pkg::REG_RANK:       rank_q <= write_data;
				default:                  ;
			endcase
		end
	end

	swnr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	swnr_dp #(
		.WINDOW_MAX (WINDOW_MAX),
		.VALUE_SPAN (VALUE_SPAN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.in_valid     (in_valid),
		.sample       (sample),
		.new_sequence (new_sequence),
		.window_len   (window_len_q),
		.rank         (rank_q),
		.out_stall    (out_stall),
		.stat         (stat),
		.out_valid    (out_valid),
		.beauty       (beauty)
	);

	// items are taken only in the idle step
	assign in_stall = ~ctl.accept;

endmodule

@@ design/swnr_check.sv @@
module swnr_check (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [swnr_pkg::SAMPLE_W-1:0]  beauty
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(beauty))
		else $error("stalled result changed");

	// result is never positive
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (beauty[swnr_pkg::SAMPLE_W-1] || beauty == '0))
		else $error("positive result");

	// one item at a time: input closes after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after accept");

	// a new result appears only while an item is being worked on
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in work");

endmodule

bind sliding_window_negative_rank_unit swnr_check u_check (.*);
